FILE: hdl/fngm_pkg.sv
package fngm_pkg;

    localparam int unsigned FNGM_CHANNELS = 2;
    localparam int unsigned NUM_LANES     = 2;
    localparam int unsigned SAMPLE_W      = 16;
    localparam int unsigned LEVEL_W       = 16;
    localparam int unsigned REG_W         = 16;
    localparam int unsigned CFG_ADDR_W    = 2;
    localparam int unsigned S_TDATA_W     = 32;
    localparam int unsigned M_TDATA_W     = 48;

    localparam logic [CFG_ADDR_W-1:0] REG_GATE_THRESHOLD = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIC_GAIN       = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MASTER_VOLUME  = 2'd2;

    localparam logic [REG_W-1:0] GATE_THRESHOLD_RST = 16'd33;
    localparam logic [REG_W-1:0] MIC_GAIN_RST       = 16'd4096;
    localparam logic [REG_W-1:0] MASTER_VOLUME_RST  = 16'd16384;

    localparam logic [LEVEL_W-1:0] ONE_Q15 = 16'd32768;

    // Q0.16 smoothing factors, zero-extended to 17 bits for signed products
    localparam logic signed [16:0] ATTACK_Q16  = 17'sd39322;
    localparam logic signed [16:0] RELEASE_Q16 = 17'sd3277;
    localparam logic signed [16:0] SMOOTH_Q16  = 17'sd5243;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENV_MUL,
        ST_ENV_ADD,
        ST_GATE_MUL,
        ST_GATE_ADD,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3
    } seq_state_t;

    typedef struct packed {
        logic env_mul;
        logic env_add;
        logic gate_mul;
        logic gate_add;
    } merge_ctl_t;

    typedef struct packed {
        logic mul1;
        logic mul2;
    } lane_ctl_t;

endpackage

FILE: hdl/frame_noise_gate_mixer.sv
// The sequencer takes one frame at a time and walks the envelope update,
// gate update and three gain multiplies in turn. Result tvalid rises when
// the result is loaded into the output register, which frees the sequencer.
// The next frame is taken while the previous result waits on m_tready.
// Reset (aresetn, synchronous, active low) clears envelope and gate gain to
// zero and loads the register defaults.
module frame_noise_gate_mixer
    import fngm_pkg::*;
#(
    parameter int unsigned CHANNELS = FNGM_CHANNELS
)
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [REG_W-1:0]       cfg_wdata,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // mic_left, mic_right
    input  logic                   s_tlast,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // out_left, out_right, gate_level
    output logic                   m_tlast
);

    seq_state_t state_reg, state_next;

    logic [REG_W-1:0] thr_reg, mic_reg, vol_reg;
    logic signed [SAMPLE_W-1:0] sample_reg [NUM_LANES];
    logic last_reg;
    logic m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic m_tlast_reg;

    logic s_fire, out_load;
    merge_ctl_t merge_ctl;
    lane_ctl_t  lane_ctl;
    logic [LEVEL_W-1:0] magnitude [NUM_LANES];
    logic signed [SAMPLE_W-1:0] lane_result [NUM_LANES];
    logic [LEVEL_W-1:0] gate_gain;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_MUL3) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        merge_ctl  = '0;
        lane_ctl   = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_ENV_MUL;
                end
            end
            ST_ENV_MUL: begin
                merge_ctl.env_mul = 1'b1;
                state_next        = ST_ENV_ADD;
            end
            ST_ENV_ADD: begin
                merge_ctl.env_add = 1'b1;
                state_next        = ST_GATE_MUL;
            end
            ST_GATE_MUL: begin
                merge_ctl.gate_mul = 1'b1;
                state_next         = ST_GATE_ADD;
            end
            ST_GATE_ADD: begin
                merge_ctl.gate_add = 1'b1;
                state_next         = ST_MUL1;
            end
            ST_MUL1: begin
                lane_ctl.mul1 = 1'b1;
                state_next    = ST_MUL2;
            end
            ST_MUL2: begin
                lane_ctl.mul2 = 1'b1;
                state_next    = ST_MUL3;
            end
            ST_MUL3: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= GATE_THRESHOLD_RST;
            mic_reg <= MIC_GAIN_RST;
            vol_reg <= MASTER_VOLUME_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_GATE_THRESHOLD: thr_reg <= cfg_wdata;
                REG_MIC_GAIN:       mic_reg <= cfg_wdata;
                REG_MASTER_VOLUME:  vol_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                sample_reg[i] <= s_tdata[i*SAMPLE_W +: SAMPLE_W];
            end
            last_reg <= s_tlast;
        end
    end

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        if (i < CHANNELS) begin : g_active
            fngm_lane u_lane (
                .aclk          (aclk),
                .sample        (sample_reg[i]),
                .ctl           (lane_ctl),
                .gate_gain     (gate_gain),
                .mic_gain      (mic_reg),
                .master_volume (vol_reg),
                .magnitude     (magnitude[i]),
                .result        (lane_result[i])
            );
        end else begin : g_off
            assign magnitude[i]   = '0;
            assign lane_result[i] = '0;
        end
    end

    fngm_merge u_merge (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctl            (merge_ctl),
        .magnitude      (magnitude),
        .gate_threshold (thr_reg),
        .gate_gain      (gate_gain)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {gate_gain, lane_result[1], lane_result[0]};
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

FILE: hdl/fngm_lane.sv
module fngm_lane
    import fngm_pkg::*;
(
    input  logic                       aclk,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  lane_ctl_t                  ctl,
    input  logic [LEVEL_W-1:0]         gate_gain,
    input  logic [REG_W-1:0]           mic_gain,
    input  logic [REG_W-1:0]           master_volume,
    output logic [LEVEL_W-1:0]         magnitude,
    output logic signed [SAMPLE_W-1:0] result
);

    logic signed [16:0] p1_reg, p1_next;
    logic signed [20:0] p2_reg, p2_next;
    logic signed [33:0] prod1, sum1;
    logic signed [33:0] prod2, sum2;
    logic signed [37:0] prod3, sum3;
    logic signed [22:0] p3;
    logic signed [16:0] neg_sample;

    always_comb begin
        neg_sample = -$signed({sample[SAMPLE_W-1], sample});
        magnitude  = sample[SAMPLE_W-1] ? neg_sample[LEVEL_W-1:0] : LEVEL_W'(sample);
    end

    // s * gain / 2^15, rounded
    always_comb begin
        prod1   = $signed({sample[SAMPLE_W-1], sample}) * $signed({1'b0, gate_gain});
        sum1    = prod1 + 34'sd16384;
        p1_next = sum1[31:15];
    end

    // p1 * mic_gain / 2^12, rounded
    always_comb begin
        prod2   = p1_reg * $signed({1'b0, mic_gain});
        sum2    = prod2 + 34'sd2048;
        p2_next = sum2[32:12];
    end

    // p2 * master_volume / 2^14, rounded and saturated
    always_comb begin
        prod3 = p2_reg * $signed({1'b0, master_volume});
        sum3  = prod3 + 38'sd8192;
        p3    = sum3[36:14];
        if (p3 > 23'sd32767) begin
            result = 16'sh7FFF;
        end else if (p3 < -23'sd32768) begin
            result = 16'sh8000;
        end else begin
            result = p3[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.mul1) begin
            p1_reg <= p1_next;
        end
        if (ctl.mul2) begin
            p2_reg <= p2_next;
        end
    end

endmodule

FILE: hdl/fngm_merge.sv
module fngm_merge
    import fngm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  merge_ctl_t         ctl,
    input  logic [LEVEL_W-1:0] magnitude [NUM_LANES],
    input  logic [REG_W-1:0]   gate_threshold,
    output logic [LEVEL_W-1:0] gate_gain
);

    logic [LEVEL_W-1:0] env_reg, env_next;
    logic [LEVEL_W-1:0] gain_reg, gain_next;
    logic signed [33:0] env_prod_reg, env_prod_next;
    logic signed [33:0] gate_prod_reg, gate_prod_next;
    logic [LEVEL_W-1:0] peak;
    logic signed [16:0] diff, gdiff, factor;
    logic signed [33:0] env_rnd, gate_rnd;
    logic signed [18:0] env_sum, gate_sum;
    logic [LEVEL_W-1:0] target;

    always_comb begin
        peak = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            if (magnitude[i] > peak) begin
                peak = magnitude[i];
            end
        end
    end

    always_comb begin
        diff          = $signed({1'b0, peak}) - $signed({1'b0, env_reg});
        factor        = (diff > 17'sd0) ? ATTACK_Q16 : RELEASE_Q16;
        env_prod_next = diff * factor;

        env_rnd = (env_prod_reg + 34'sd32768) >>> 16;
        env_sum = $signed({3'b000, env_reg}) + env_rnd[18:0];
        priority if (env_sum < 19'sd0) begin
            env_next = '0;
        end else if (env_sum > $signed({3'b000, ONE_Q15})) begin
            env_next = ONE_Q15;
        end else begin
            env_next = env_sum[LEVEL_W-1:0];
        end
    end

    always_comb begin
        target = (env_reg > gate_threshold || gate_threshold == '0) ? ONE_Q15 : '0;
        gdiff          = $signed({1'b0, target}) - $signed({1'b0, gain_reg});
        gate_prod_next = gdiff * SMOOTH_Q16;

        gate_rnd = (gate_prod_reg + 34'sd32768) >>> 16;
        gate_sum = $signed({3'b000, gain_reg}) + gate_rnd[18:0];
        priority if (gate_sum < 19'sd0) begin
            gain_next = '0;
        end else if (gate_sum > $signed({3'b000, ONE_Q15})) begin
            gain_next = ONE_Q15;
        end else begin
            gain_next = gate_sum[LEVEL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            env_reg  <= '0;
            gain_reg <= '0;
        end else begin
            if (ctl.env_add) begin
                env_reg <= env_next;
            end
            if (ctl.gate_add) begin
                gain_reg <= gain_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.env_mul) begin
            env_prod_reg <= env_prod_next;
        end
        if (ctl.gate_mul) begin
            gate_prod_reg <= gate_prod_next;
        end
    end

    assign gate_gain = gain_reg;

endmodule

FILE: tb/fngm_result_checker.sv
`timescale 1ns / 100ps

module fngm_result_checker
    import fngm_pkg::*;
#(
    parameter int unsigned CHANNELS = FNGM_CHANNELS
)
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [REG_W-1:0]      cfg_wdata,

    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // mic_left, mic_right
    input  logic                  s_tlast,

    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,   // out_left, out_right, gate_level
    input  logic                  m_tlast,

    output int                    frames_pending,
    output int                    fail_count
);

    localparam longint UNITY = longint'(ONE_Q15);

    typedef struct packed {
        logic [SAMPLE_W-1:0] out_left;
        logic [SAMPLE_W-1:0] out_right;
        logic [LEVEL_W-1:0]  gate_level;
        logic                block_last;
    } mixed_frame_t;

    mixed_frame_t     expected_frames[$];
    logic [REG_W-1:0] threshold_reg;
    logic [REG_W-1:0] mic_gain_reg;
    logic [REG_W-1:0] volume_reg;
    int               envelope_q15;
    int               gate_gain_q15;
    int               mismatches = 0;

    // round to nearest, ties up: add half an LSB, then floor
    function automatic longint round_q(input longint p, input int sh);
        return (p + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic int clamp_unit(input longint v);
        if (v < 0) return 0;
        if (v > UNITY) return int'(UNITY);
        return int'(v);
    endfunction

    function automatic logic [SAMPLE_W-1:0] scale_lane(input logic signed [SAMPLE_W-1:0] s);
        longint p;
        p = round_q(longint'(s) * gate_gain_q15, 15);
        p = round_q(p * longint'(mic_gain_reg), 12);
        p = round_q(p * longint'(volume_reg), 14);
        if (p > 32767) p = 32767;
        else if (p < -32768) p = -32768;
        return p[SAMPLE_W-1:0];
    endfunction

    // advances envelope and gate gain, returns the gained frame
    function automatic mixed_frame_t mix_frame(input logic [S_TDATA_W-1:0] data,
                                               input logic last);
        logic signed [SAMPLE_W-1:0] lane [NUM_LANES];
        int                         peak;
        int                         mag;
        int                         diff;
        int                         target;
        mixed_frame_t               r;
        peak = 0;
        for (int c = 0; c < NUM_LANES; c++) begin
            lane[c] = data[c*SAMPLE_W +: SAMPLE_W];
            mag = (lane[c] < 0) ? -int'(lane[c]) : int'(lane[c]);
            if (c < CHANNELS && mag > peak) peak = mag;
        end
        diff = peak - envelope_q15;
        envelope_q15 = clamp_unit(envelope_q15 +
            round_q(longint'(diff) * (diff > 0 ? ATTACK_Q16 : RELEASE_Q16), 16));
        // zero threshold opens the gate even with a silent envelope
        target = (envelope_q15 > int'(threshold_reg) || threshold_reg == '0) ? int'(UNITY) : 0;
        gate_gain_q15 = clamp_unit(gate_gain_q15 +
            round_q(longint'(target - gate_gain_q15) * SMOOTH_Q16, 16));
        r.out_left   = (CHANNELS > 0) ? scale_lane(lane[0]) : '0;
        r.out_right  = (CHANNELS > 1) ? scale_lane(lane[1]) : '0;
        r.gate_level = gate_gain_q15[LEVEL_W-1:0];
        r.block_last = last;
        return r;
    endfunction

    function automatic int field_differs(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
        if (want === got) return 0;
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge aclk) begin
        mixed_frame_t want;
        if (!aresetn) begin
            expected_frames.delete();
            threshold_reg = GATE_THRESHOLD_RST;
            mic_gain_reg  = MIC_GAIN_RST;
            volume_reg    = MASTER_VOLUME_RST;
            envelope_q15  = 0;
            gate_gain_q15 = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_GATE_THRESHOLD: threshold_reg = cfg_wdata;
                    REG_MIC_GAIN:       mic_gain_reg  = cfg_wdata;
                    REG_MASTER_VOLUME:  volume_reg    = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_frames.push_back(mix_frame(s_tdata, s_tlast));
            if (m_tvalid && m_tready) begin
                if (expected_frames.size() == 0) begin
                    $display("%0t: unexpected result transaction expected none actual %h/%b",
                             $time, m_tdata, m_tlast);
                    mismatches++;
                end else begin
                    want = expected_frames.pop_front();
                    mismatches += field_differs("out_left", want.out_left, m_tdata[15:0]);
                    mismatches += field_differs("out_right", want.out_right, m_tdata[31:16]);
                    mismatches += field_differs("gate_level", want.gate_level, m_tdata[47:32]);
                    mismatches += field_differs("block_last", 16'(want.block_last),
                                                16'(m_tlast));
                end
            end
        end
        frames_pending <= expected_frames.size();
        fail_count     <= mismatches;
    end

endmodule

FILE: tb/tb_frame_noise_gate_mixer.sv
`timescale 1ns / 100ps

module tb_frame_noise_gate_mixer;
    import fngm_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;

    localparam int RANDOM_PHASES    = 12;
    localparam int FRAMES_PER_PHASE = 160;
    localparam int SETTLE_CYCLES    = 16;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT   = 4000;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_BURSTY
    } ready_mode_t;

    typedef enum logic [1:0] {
        SEG_QUIET,
        SEG_SPEECH,
        SEG_EXTREME,
        SEG_NOISE
    } segment_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [REG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tready  = 1'b0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire [M_TDATA_W-1:0]   m_tdata;
    wire                   m_tlast;

    int frames_pending;
    int fail_count;

    // sender state
    int       burst_left = 0;
    int       gap_max    = 0;
    segment_t seg_kind   = SEG_QUIET;
    int       seg_left   = 0;
    int       seg_amp    = 0;
    int       block_left = 0;

    // receiver state
    ready_mode_t ready_mode    = READY_ALWAYS;
    int          hold_requests = 0;
    int          holds_served  = 0;
    int          hold_left     = 0;
    int          run_left      = 0;
    logic        run_ready     = 1'b1;

    int idle_cycles = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    frame_noise_gate_mixer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    fngm_result_checker result_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .frames_pending (frames_pending),
        .fail_count     (fail_count)
    );

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = LONG_HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else begin
            case (ready_mode)
                READY_ALWAYS: m_tready <= 1'b1;
                READY_RANDOM: m_tready <= ($urandom_range(0, 99) < 60);
                default: begin
                    if (run_left == 0) begin
                        run_ready = !run_ready;
                        run_left  = run_ready ? $urandom_range(1, 20) : $urandom_range(1, 8);
                    end
                    run_left--;
                    m_tready <= run_ready;
                end
            endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_frame_noise_gate_mixer failed");
            $finish;
        end
    end

    task automatic put_frame(input logic [SAMPLE_W-1:0] left, input logic [SAMPLE_W-1:0] right,
                             input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {right, left};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_idle();
        @(posedge aclk);
        while (frames_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // spare index goes last with junk data; it must not touch anything
    task automatic load_regs(input logic [REG_W-1:0] thr, input logic [REG_W-1:0] mic,
                             input logic [REG_W-1:0] vol);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_GATE_THRESHOLD;
        cfg_wdata <= thr;
        @(posedge aclk);
        cfg_addr  <= REG_MIC_GAIN;
        cfg_wdata <= mic;
        @(posedge aclk);
        cfg_addr  <= REG_MASTER_VOLUME;
        cfg_wdata <= vol;
        @(posedge aclk);
        cfg_addr  <= REG_SPARE;
        cfg_wdata <= 16'($urandom_range(0, 65535));
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [REG_W-1:0] pick_threshold();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return ONE_Q15;
            2: return 16'hFFFF;
            3: return 16'd32767;
            default: return 16'($urandom_range(1, 2000));
        endcase
    endfunction

    function automatic logic [REG_W-1:0] pick_gain(input int unity);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 16'hFFFF;
            2: return 16'(unity);
            3: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(unity / 2, unity * 2));
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] segment_sample();
        case (seg_kind)
            SEG_EXTREME: begin
                case ($urandom_range(0, 4))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'hFFFF;
                    3: return 16'h0001;
                    default: return 16'h0000;
                endcase
            end
            SEG_NOISE: return 16'($urandom_range(0, 65535));
            default: return 16'(int'($urandom_range(0, 2 * seg_amp)) - seg_amp);
        endcase
    endfunction

    // mostly quiet/loud stretches so the gate opens and closes; some noise
    task automatic next_frame(output logic [SAMPLE_W-1:0] left,
                              output logic [SAMPLE_W-1:0] right, output logic last);
        if (seg_left == 0) begin
            seg_left = $urandom_range(4, 80);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: seg_kind = SEG_QUIET;
                4, 5, 6, 7: seg_kind = SEG_SPEECH;
                8:          seg_kind = SEG_EXTREME;
                default:    seg_kind = SEG_NOISE;
            endcase
            seg_amp = (seg_kind == SEG_QUIET) ? $urandom_range(0, 300)
                                              : $urandom_range(500, 32767);
        end
        seg_left--;
        left  = segment_sample();
        right = segment_sample();
        if (block_left == 0) block_left = $urandom_range(1, 16);
        block_left--;
        last = (block_left == 0);
    endtask

    initial begin
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
        logic                last;

        repeat (11) @(posedge aclk);
        aresetn    <= 1'b1;
        gap_max    = 2;
        ready_mode <= READY_RANDOM;

        // register defaults
        put_frame(16'h0000, 16'h0000, 1'b0);
        put_frame(16'h7FFF, 16'h8000, 1'b1);
        put_frame(16'h8000, 16'h7FFF, 1'b0);
        put_frame(16'hFFFF, 16'h0001, 1'b0);
        put_frame(16'h0001, 16'hFFFF, 1'b1);
        repeat (3) put_frame(16'h7FFF, 16'h7FFF, 1'b0);
        put_frame(16'h0000, 16'h0000, 1'b1);
        s_tvalid <= 1'b0;

        // zero threshold, full gains: gate opens on silence, outputs saturate
        wait_idle();
        load_regs(16'd0, 16'hFFFF, 16'hFFFF);
        repeat (2) put_frame(16'h0000, 16'h0000, 1'b0);
        put_frame(16'h0BB8, 16'hF448, 1'b0);
        put_frame(16'h7FFF, 16'h8000, 1'b1);
        s_tvalid <= 1'b0;

        // threshold above one: gate closes for good; zero gains
        wait_idle();
        load_regs(16'hFFFF, 16'd0, 16'd0);
        repeat (2) put_frame(16'h8000, 16'h8000, 1'b0);
        put_frame(16'h7FFF, 16'h7FFF, 1'b1);
        s_tvalid <= 1'b0;

        // envelope clamps at one, which does not exceed a threshold of one
        wait_idle();
        load_regs(ONE_Q15, MIC_GAIN_RST, MASTER_VOLUME_RST);
        repeat (3) put_frame(16'h8000, 16'h8000, 1'b0);
        put_frame(16'h0000, 16'h0000, 1'b1);
        s_tvalid <= 1'b0;

        wait_idle();
        load_regs(16'd32767, MIC_GAIN_RST, 16'h8000);
        repeat (3) put_frame(16'h8000, 16'h8000, 1'b0);
        s_tvalid <= 1'b0;

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_idle();
            load_regs(pick_threshold(), pick_gain(4096), pick_gain(16384));
            ready_mode <= ready_mode_t'(ph % 3);
            case (ph % 4)
                0: gap_max = 3;
                1: gap_max = 9;
                2: gap_max = 20;
                default: gap_max = 0;
            endcase
            if (ph % 5 == 1) hold_requests <= hold_requests + 1;
            repeat (FRAMES_PER_PHASE) begin
                next_frame(left, right, last);
                put_frame(left, right, last);
            end
            s_tvalid <= 1'b0;
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("tb_frame_noise_gate_mixer passed");
        end else begin
            $display("tb_frame_noise_gate_mixer failed");
        end
        $finish;
    end

endmodule
